>>> rtl/cevb_pkg.sv
package cevb_pkg;

    // field widths of the stream items
    localparam int IN_TS_W    = 48;
    localparam int FIELD_W    = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 64;

    // configuration port
    localparam int          PADDR_W      = 3;
    localparam int          PDATA_W      = 32;
    localparam logic [2:0]  REG_WINDOW   = 3'd0;
    localparam logic [31:0] WINDOW_RESET = 32'd1000;

    // command carried in the slave-side tuser
    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one stored hit, laid out as the master-side tdata (rel_time lowest)
    typedef struct packed {
        logic [FIELD_W-1:0] adc;
        logic [FIELD_W-1:0] channel;
        logic [FIELD_W-1:0] module_id;
        logic [FIELD_W-1:0] rel_time;
    } t_hit;

endpackage

>>> rtl/coincidence_event_builder.sv
// Coincidence-window event builder. Time-ordered hits arrive on the slave
// stream (tuser = 0 for a hit, 1 for a flush). A hit whose gap to the
// previous hit is below the window register joins the open event and is written
// straight into the hit store, one item per cycle when no drain runs. A hit
// outside the window, or a flush, starts a drain: the stored hits are read
// back from the store one at a time and sent on the master stream with
// tlast on the final hit and tuser set when hits were dropped because the
// store was full. Each hit of a drain passes a store read state and an
// output load state, and no new item is taken during the drain; the hit
// that closed the event is held aside and opens the next event as the drain
// ends. A timestamp that goes backwards drops the open event silently.
// Timestamps are used modulo 2**TS_BITS. The store needs no clearing after
// reset.
module coincidence_event_builder #(
    parameter int MAX_HITS = 64,
    parameter int TS_BITS  = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // timestamp[47:0], module_req[63:48], channel[79:64], adc_value[95:80]
    input  logic [cevb_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // cmd[0]
    input  logic                                i_s_tuser,
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // rel_time[15:0], hit_module[31:16], hit_channel[47:32], hit_adc[63:48]
    output logic [cevb_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    // truncated[0]
    output logic                                o_m_tuser,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cevb_pkg::PADDR_W-1:0]        paddr,
    input  logic [cevb_pkg::PDATA_W-1:0]        pwdata,
    output logic [cevb_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int ADDR_W = $clog2(MAX_HITS);
    localparam int CNT_W  = $clog2(MAX_HITS + 1);
    localparam int CMP_W  = (TS_BITS > 32) ? TS_BITS : 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    // registers
    logic [1:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [ADDR_W-1:0]            r_idx, n_idx;
    logic [TS_BITS-1:0]           r_first, n_first;
    logic [TS_BITS-1:0]           r_prev, n_prev;
    logic                         r_ovf, n_ovf;
    logic                         r_pend, n_pend;
    cevb_pkg::t_hit               r_pend_hit, n_pend_hit;
    logic [TS_BITS-1:0]           r_pend_ts, n_pend_ts;
    logic [31:0]                  r_window;
    logic                         r_out_valid, n_out_valid;
    cevb_pkg::t_hit               r_out_hit;
    logic                         r_out_last;
    logic                         r_out_trunc;
    cevb_pkg::t_hit               r_rd_data;

    // hit store
    cevb_pkg::t_hit               r_store [MAX_HITS];

    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    cevb_pkg::t_hit               mem_wdata;

    logic                         in_accept;
    logic [TS_BITS-1:0]           in_ts;
    logic [TS_BITS-1:0]           gap;
    logic [TS_BITS-1:0]           rel_full;
    logic [cevb_pkg::FIELD_W-1:0] rel_sat;
    logic                         backward;
    logic                         joins;
    cevb_pkg::t_hit               in_hit;
    logic                         out_free;
    logic                         out_load;
    logic                         is_last;
    logic                         cfg_wr;

    // input decode
    assign in_accept        = i_s_tvalid && o_s_tready;
    assign in_ts            = TS_BITS'(i_s_tdata[cevb_pkg::IN_TS_W-1:0]);
    assign in_hit.rel_time  = '0;
    assign in_hit.module_id = i_s_tdata[63:48];
    assign in_hit.channel   = i_s_tdata[79:64];
    assign in_hit.adc       = i_s_tdata[95:80];

    // window test and relative time
    assign gap      = in_ts - r_prev;
    assign rel_full = in_ts - r_first;
    assign backward = in_ts < r_prev;
    assign joins    = CMP_W'(gap) < CMP_W'(r_window);
    assign rel_sat  = (rel_full > TS_BITS'(17'h0FFFF)) ? '1 : rel_full[cevb_pkg::FIELD_W-1:0];

    // drain bookkeeping
    assign out_free = !r_out_valid || i_m_tready;
    assign is_last  = CNT_W'(r_idx) == (r_count - CNT_W'(1));
    assign out_load = (r_state == S_LOAD) && out_free;

    // control and store write
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_first    = r_first;
        n_prev     = r_prev;
        n_ovf      = r_ovf;
        n_pend     = r_pend;
        n_pend_hit = r_pend_hit;
        n_pend_ts  = r_pend_ts;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = in_hit;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_s_tuser == cevb_pkg::CMD_FLUSH) begin
                        if (r_count != '0) begin
                            n_pend  = 1'b0;
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end else if (r_count == '0 || backward) begin
                        // open a fresh event
                        mem_we  = 1'b1;
                        n_first = in_ts;
                        n_prev  = in_ts;
                        n_count = CNT_W'(1);
                        n_ovf   = 1'b0;
                    end else if (joins) begin
                        if (r_count < CNT_W'(MAX_HITS)) begin
                            mem_we             = 1'b1;
                            mem_waddr          = r_count[ADDR_W-1:0];
                            mem_wdata.rel_time = rel_sat;
                            n_count            = r_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_prev = in_ts;
                    end else begin
                        // hold the closing hit aside and drain
                        n_pend     = 1'b1;
                        n_pend_hit = in_hit;
                        n_pend_ts  = in_ts;
                        n_idx      = '0;
                        n_state    = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                        n_ovf   = 1'b0;
                        if (r_pend) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_pend_hit;
                            n_first   = r_pend_ts;
                            n_prev    = r_pend_ts;
                            n_count   = CNT_W'(1);
                            n_pend    = 1'b0;
                        end else begin
                            n_count = '0;
                        end
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && !i_m_tready);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_first     <= '0;
            r_prev      <= '0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_ovf       <= n_ovf;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_hit <= n_pend_hit;
        r_pend_ts  <= n_pend_ts;
        if (out_load) begin
            r_out_hit   <= r_rd_data;
            r_out_last  <= is_last;
            r_out_trunc <= r_ovf;
        end
    end

    // hit store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_store[r_idx];
    end

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= cevb_pkg::WINDOW_RESET;
        end else if (cfg_wr && paddr == cevb_pkg::REG_WINDOW) begin
            r_window <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == cevb_pkg::REG_WINDOW) ? r_window : '0;

    // outputs
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_hit;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_trunc;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_HITS))
        else $error("hit count beyond store depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CNT_W'(MAX_HITS))
        else $error("overflow flag set with room left in the store");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count != '0 && CNT_W'(r_idx) < r_count))
        else $error("drain index outside the stored hits");

    a_load_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && is_last) |=> (r_state == S_IDLE && r_out_last))
        else $error("final hit of an event not marked");

endmodule

>>> test/cevb_checker.sv
`timescale 1ns / 100ps

module cevb_checker #(
    parameter int MAX_HITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream as seen at the block
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // timestamp[47:0], module_req[63:48], channel[79:64], adc_value[95:80]
    input  logic [cevb_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // cmd[0]
    input  logic                            i_s_tuser,
    // master stream as seen at the block
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // rel_time[15:0], hit_module[31:16], hit_channel[47:32], hit_adc[63:48]
    input  logic [cevb_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    // truncated[0]
    input  logic                            i_m_tuser,
    // configuration port
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [cevb_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [cevb_pkg::PDATA_W-1:0]    i_pwdata,
    input  logic [cevb_pkg::PDATA_W-1:0]    i_prdata,
    input  logic                            i_pready,
    output int                              o_fail_count,
    output int                              o_pending
);

    // one hit as it should leave the block
    typedef struct packed {
        cevb_pkg::t_hit hit;
        logic           last;
        logic           trunc;
    } t_event_hit;

    // mirror of the event being built
    cevb_pkg::t_hit              open_hits[$];
    logic [cevb_pkg::IN_TS_W-1:0] first_ts;
    logic [cevb_pkg::IN_TS_W-1:0] last_ts;
    logic                        dropped;
    logic [31:0]                 window;

    // hits owed on the master side, oldest first
    t_event_hit                  owed_hits[$];
    int                          fails;

    task automatic flag(input string what);
        fails++;
        if (fails <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    // hand the open event over to the owed list
    task automatic drain_event();
        t_event_hit e;
        for (int k = 0; k < open_hits.size(); k++) begin
            e.hit   = open_hits[k];
            e.last  = (k == open_hits.size() - 1);
            e.trunc = dropped;
            owed_hits.insert(owed_hits.size(), e);
        end
        open_hits.delete();
        dropped = 1'b0;
    endtask

    task automatic open_event(input logic [cevb_pkg::IN_TS_W-1:0] ts,
                              input cevb_pkg::t_hit h);
        first_ts = ts;
        last_ts  = ts;
        dropped  = 1'b0;
        open_hits.delete();
        open_hits.insert(open_hits.size(), h);
    endtask

    // predict what one accepted item does
    task automatic take_item(input logic cmd, input logic [cevb_pkg::IN_DATA_W-1:0] data);
        logic [cevb_pkg::IN_TS_W-1:0] ts;
        logic [cevb_pkg::IN_TS_W-1:0] rel;
        cevb_pkg::t_hit               h;
        ts          = data[cevb_pkg::IN_TS_W-1:0];
        h.rel_time  = '0;
        h.module_id = data[63:48];
        h.channel   = data[79:64];
        h.adc       = data[95:80];
        if (cmd == cevb_pkg::CMD_FLUSH) begin
            if (open_hits.size() != 0)
                drain_event();
        end else if (open_hits.size() == 0 || ts < last_ts) begin
            // empty block or time went backwards: start afresh
            open_event(ts, h);
        end else if (ts - last_ts < {16'd0, window}) begin
            rel        = ts - first_ts;
            h.rel_time = (rel > 48'hFFFF) ? 16'hFFFF : rel[15:0];
            if (open_hits.size() < MAX_HITS)
                open_hits.insert(open_hits.size(), h);
            else
                dropped = 1'b1;
            last_ts = ts;
        end else begin
            drain_event();
            open_event(ts, h);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        cevb_pkg::t_hit got;
        t_event_hit     want;
        if (!i_rst_n) begin
            open_hits.delete();
            owed_hits.delete();
            first_ts = '0;
            last_ts  = '0;
            dropped  = 1'b0;
            window   = cevb_pkg::WINDOW_RESET;
            fails    = 0;
        end else begin
            // register writes and read-back
            if (i_psel && i_penable && i_pready && i_paddr == cevb_pkg::REG_WINDOW) begin
                if (i_pwrite)
                    window = i_pwdata;
                else if (i_prdata !== window)
                    flag($sformatf("window read-back: expected %0d got %0d",
                                   window, i_prdata));
            end
            if (i_s_tvalid && i_s_tready)
                take_item(i_s_tuser, i_s_tdata);
            // compare each item leaving the block
            if (i_m_tvalid && i_m_tready) begin
                got = cevb_pkg::t_hit'(i_m_tdata);
                if (owed_hits.size() == 0) begin
                    flag($sformatf({"unexpected hit: rel=%0d mod=%0d ch=%0d adc=%0d ",
                                    "last=%0b trunc=%0b"},
                                   got.rel_time, got.module_id, got.channel, got.adc,
                                   i_m_tlast, i_m_tuser));
                end else begin
                    want = owed_hits.pop_front();
                    if (want.hit !== got || want.last !== i_m_tlast ||
                        want.trunc !== i_m_tuser)
                        flag($sformatf({"hit mismatch: expected rel=%0d mod=%0d ch=%0d ",
                                        "adc=%0d last=%0b trunc=%0b, got rel=%0d mod=%0d ",
                                        "ch=%0d adc=%0d last=%0b trunc=%0b"},
                                       want.hit.rel_time, want.hit.module_id,
                                       want.hit.channel, want.hit.adc, want.last, want.trunc,
                                       got.rel_time, got.module_id, got.channel, got.adc,
                                       i_m_tlast, i_m_tuser));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_hits.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // timestamp[47:0], module_req[63:48], channel[79:64], adc_value[95:80]
    logic [cevb_pkg::IN_DATA_W-1:0]  s_tdata;
    // cmd[0]
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // rel_time[15:0], hit_module[31:16], hit_channel[47:32], hit_adc[63:48]
    logic [cevb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    // truncated[0]
    logic                            m_tuser;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [cevb_pkg::PADDR_W-1:0]    paddr;
    logic [cevb_pkg::PDATA_W-1:0]    pwdata;
    logic [cevb_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;

    int                              fail_count;
    int                              pending;
    logic                            calm;
    logic                            quiet_tx;
    logic                            quiet_rx;
    int                              rx_stall;
    logic [cevb_pkg::IN_TS_W-1:0]    hit_ts;

    coincidence_event_builder #(
        .MAX_HITS(64),
        .TS_BITS (48)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast),
        .o_m_tuser (m_tuser),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    cevb_checker #(
        .MAX_HITS(64)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // master-side back-pressure in bursts, with quiet stretches
    initial begin
        m_tready = 1'b0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        rx_stall = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 49) == 0)
                quiet_tx = !quiet_tx;
            if ($urandom_range(0, 49) == 0)
                quiet_rx = !quiet_rx;
            if (rx_stall > 0) begin
                m_tready = 1'b0;
                rx_stall--;
            end else if (!calm && !quiet_rx && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                rx_stall = $urandom_range(0, 5);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(input logic cmd, input logic [cevb_pkg::IN_TS_W-1:0] ts,
                             input logic [15:0] mod, input logic [15:0] chan,
                             input logic [15:0] adc);
        @(negedge i_clk);
        if (!calm && !quiet_tx && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {adc, chan, mod, ts};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_hit(input logic [cevb_pkg::IN_TS_W-1:0] ts);
        send_item(cevb_pkg::CMD_HIT, ts, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // hit fields of a flush carry junk
    task automatic send_flush();
        send_item(cevb_pkg::CMD_FLUSH, 48'({$urandom, $urandom}), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic apb_access(input logic wr, input logic [cevb_pkg::PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = cevb_pkg::REG_WINDOW;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop offering, let all owed hits out and the held hit settle
    task automatic settle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [cevb_pkg::IN_TS_W-1:0] join_gap(input logic [31:0] w);
        logic [31:0] g;
        case ($urandom_range(0, 3))
            0: g = 32'd0;
            1: g = w - 32'd1;
            2: g = $urandom_range(w - 32'd1, 0);
            default: g = (w > 32'd16) ? $urandom_range(15, 0) : $urandom_range(w - 32'd1, 0);
        endcase
        return {16'd0, g};
    endfunction

    function automatic logic [cevb_pkg::IN_TS_W-1:0] close_gap(input logic [31:0] w);
        case ($urandom_range(0, 2))
            0: return {16'd0, w};
            1: return {16'd0, w} + 48'($urandom_range(1000, 0));
            default: return {16'd0, w} + 48'($urandom & 32'hF_FFFF);
        endcase
    endfunction

    // one window setting with a run of random hits and flushes
    task automatic run_phase(input logic [31:0] w, input int count, input logic last_part);
        int          n;
        int          sel;
        int          burst;
        logic [63:0] r64;
        calm = last_part;
        apb_access(1'b1, w);
        apb_access(1'b0, '0);
        n = 0;
        while (n < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                send_flush();
                n++;
            end else if (sel < 14) begin
                // backwards step, or a jump anywhere in the timestamp range
                r64 = {$urandom, $urandom};
                if (sel < 11 && hit_ts != 0)
                    hit_ts = r64[cevb_pkg::IN_TS_W-1:0] % hit_ts;
                else
                    hit_ts = r64[cevb_pkg::IN_TS_W-1:0];
                send_hit(hit_ts);
                n++;
            end else if (sel < 16 && w != 0) begin
                // event around the store depth, often longer than the store
                burst = $urandom_range(60, 72);
                repeat (burst) begin
                    hit_ts += join_gap(w);
                    send_hit(hit_ts);
                end
                n += burst;
            end else if (sel < 60 && w != 0) begin
                hit_ts += join_gap(w);
                send_hit(hit_ts);
                n++;
            end else begin
                hit_ts += close_gap(w);
                send_hit(hit_ts);
                n++;
            end
        end
        send_flush();
        settle();
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = cevb_pkg::CMD_HIT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = cevb_pkg::REG_WINDOW;
        pwdata   = '0;
        calm     = 1'b0;
        hit_ts   = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset window, edges of the fields and of the window test
        apb_access(1'b0, '0);
        send_flush();
        send_item(cevb_pkg::CMD_HIT, 48'd0, 16'h0000, 16'h0000, 16'h0000);
        send_item(cevb_pkg::CMD_HIT, 48'd999, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_hit(48'd1999);
        send_hit(48'd500);
        send_flush();
        send_hit(48'hFFFF_FFFF_FC19);
        send_hit(48'hFFFF_FFFF_FFFF);
        send_hit(48'hFFFF_FFFF_FFFF);
        send_flush();
        settle();

        // widest window: relative time saturates
        apb_access(1'b1, 32'hFFFF_FFFF);
        send_hit(48'd0);
        send_hit(48'd70000);
        send_hit(48'd70000 + 48'hFFFF_FFFE);
        send_flush();
        settle();

        // zero window: one hit per event
        apb_access(1'b1, 32'd0);
        send_hit(48'd5);
        send_hit(48'd5);
        send_hit(48'd6);
        send_flush();
        settle();

        // random part over several window settings
        run_phase(32'd1000, 60, 1'b0);
        run_phase(32'd1, 50, 1'b0);
        run_phase($urandom_range(5000, 2), 60, 1'b0);
        run_phase(32'hFFFF_FFFF, 50, 1'b0);
        run_phase($urandom, 40, 1'b0);
        run_phase(32'd0, 40, 1'b0);
        run_phase($urandom_range(3000, 20), 60, 1'b1);

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
